@@ rtl/damt_pkg.sv @@
// Shared types and constants of the descriptor allocate/map table.
// Used by the controller, the datapath, the top level and the checker.
package damt_pkg;

  // Bitmap rows are 32 slots wide; the slot limit register caps the usable table.
  localparam int WORD_BITS = 32;
  localparam int OFS_W     = 5;
  localparam int LIM_W     = 10;
  localparam int BASE_W    = 11;
  localparam int STORE_CAP = 512;

  localparam logic [2:0] ACT_ALLOC     = 3'd0;
  localparam logic [2:0] ACT_ALLOC_MAP = 3'd1;
  localparam logic [2:0] ACT_CLAIM     = 3'd2;
  localparam logic [2:0] ACT_FREE      = 3'd3;
  localparam logic [2:0] ACT_MAP       = 3'd4;
  localparam logic [2:0] ACT_UNMAP     = 3'd5;
  localparam logic [2:0] ACT_LOOKUP    = 3'd6;
  localparam logic [2:0] ACT_CHECK     = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RANGE,
    S_EVAL,
    S_POST
  } state_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic next_row;
    logic fail;
    logic eval;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic oor;
    logic is_alloc;
    logic found;
    logic last_row;
  } dp_sts_t;

endpackage

@@ rtl/damt_ctrl.sv @@
// Controller state machine of the descriptor allocate/map table.
// Depends on damt_pkg; drives the datapath through dp_cmd_t and reads dp_sts_t.
module damt_ctrl
  import damt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   eval_done;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign eval_done = !sts_i.is_alloc || sts_i.found || sts_i.last_row;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_RANGE;
      end
      S_RANGE: begin
        state_d = sts_i.oor ? S_POST : S_EVAL;
      end
      S_EVAL: begin
        if (eval_done) state_d = S_POST;
      end
      S_POST: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_RANGE: begin
        cmd_o.rd   = 1'b1;
        cmd_o.fail = sts_i.oor;
      end
      S_EVAL: begin
        if (eval_done) begin
          cmd_o.eval = 1'b1;
        end else begin
          cmd_o.rd       = 1'b1;
          cmd_o.next_row = 1'b1;
        end
      end
      S_POST: begin
        cmd_o.out_load = out_free;
      end
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.out_load ? 1'b1 : (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/damt_dp.sv @@
// Datapath of the descriptor allocate/map table: limit register, bitmap and
// identifier memories, row search and result registers. Depends on damt_pkg.
module damt_dp
  import damt_pkg::*;
#(
  parameter int SLOTS          = 256,
  parameter int RESERVED_SLOTS = 3,
  parameter int ID_WIDTH       = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [8:0]    cfg_slot_limit_i,
  input  logic [2:0]    action_i,
  input  logic [15:0]   slot_i,
  input  logic [15:0]   min_slot_i,
  input  logic [15:0]   system_id_i,
  input  dp_cmd_t       cmd_i,
  output dp_sts_t       sts_o,
  output logic [1:0]    status_o,
  output logic [7:0]    slot_out_o,
  output logic [15:0]   system_id_out_o
);

  localparam int STORE = (SLOTS < STORE_CAP) ? SLOTS : STORE_CAP;
  localparam int IDX_W = $clog2(STORE);
  localparam int ROWS  = (STORE + WORD_BITS - 1) / WORD_BITS;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [8:0]          slot_limit_q;
  logic [LIM_W-1:0]    lim;

  logic [2:0]          action_q;
  logic [15:0]         slot_q;
  logic [15:0]         start_q;
  logic [ID_WIDTH-1:0] sid_q;
  logic [ROW_W-1:0]    row_ptr_q;
  logic                first_q;

  logic [15:0]         start_in;
  logic                is_alloc_in;
  logic [47:0]         sid_wide;
  logic [ID_WIDTH-1:0] sid_in;

  logic [WORD_BITS-1:0] used_mem   [ROWS];
  logic [WORD_BITS-1:0] mapped_mem [ROWS];
  logic [ID_WIDTH-1:0]  id_mem     [STORE];
  logic [ROWS-1:0]      row_vld_q;

  logic [WORD_BITS-1:0] used_rd_q, mapped_rd_q;
  logic                 rd_vld_q;
  logic [ID_WIDTH-1:0]  id_rd_q;
  logic [ROW_W-1:0]     rd_row;
  logic [IDX_W-1:0]     slot_idx;

  logic [WORD_BITS-1:0] used_word, mapped_word;
  logic [BASE_W-1:0]    base, rem, next_base, found_slot;
  logic [WORD_BITS-1:0] lo_ok, hi_ok, free_bits, lowest;
  logic [OFS_W-1:0]     enc;
  logic                 is_alloc;
  logic [OFS_W-1:0]     bit_sel;
  logic                 u_bit, m_bit;
  logic [WORD_BITS-1:0] bit_mask;
  logic [ID_WIDTH+15:0] id_wide;

  logic [WORD_BITS-1:0] used_wd, mapped_wd;
  logic                 row_we, id_we;
  logic [IDX_W-1:0]     id_waddr;
  logic [1:0]           st_n;
  logic [7:0]           slot_n;
  logic [15:0]          id_n;

  logic [1:0]           res_status_q;
  logic [7:0]           res_slot_q;
  logic [15:0]          res_id_q;

  // Effective limit: the register value, capped at the table size.
  assign lim = ({1'b0, slot_limit_q} > LIM_W'(STORE)) ? LIM_W'(STORE)
                                                      : {1'b0, slot_limit_q};

  assign is_alloc_in = (action_i == ACT_ALLOC) || (action_i == ACT_ALLOC_MAP);
  assign start_in    = (min_slot_i < 16'(RESERVED_SLOTS)) ? 16'(RESERVED_SLOTS) : min_slot_i;
  assign sid_wide    = {32'd0, system_id_i};
  assign sid_in      = sid_wide[ID_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_limit_q <= 9'd256;
    end else if (cfg_we_i) begin
      slot_limit_q <= cfg_slot_limit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q  <= action_i;
      slot_q    <= slot_i;
      start_q   <= start_in;
      sid_q     <= sid_in;
      row_ptr_q <= is_alloc_in ? ROW_W'(start_in >> OFS_W) : ROW_W'(slot_i >> OFS_W);
      first_q   <= 1'b1;
    end else if (cmd_i.next_row) begin
      row_ptr_q <= row_ptr_q + ROW_W'(1);
      first_q   <= 1'b0;
    end
  end

  assign is_alloc = (action_q == ACT_ALLOC) || (action_q == ACT_ALLOC_MAP);
  assign slot_idx = IDX_W'(slot_q);
  assign rd_row   = cmd_i.next_row ? (row_ptr_q + ROW_W'(1)) : row_ptr_q;

  // Registered reads of the bitmap rows and the identifier entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      used_rd_q   <= used_mem[rd_row];
      mapped_rd_q <= mapped_mem[rd_row];
      rd_vld_q    <= row_vld_q[rd_row];
      id_rd_q     <= id_mem[slot_idx];
    end
  end

  // Rows never written read as all free and unmapped.
  assign used_word   = rd_vld_q ? used_rd_q : '0;
  assign mapped_word = rd_vld_q ? mapped_rd_q : '0;

  // Lowest free slot in the current row, bounded by the start and the limit.
  assign base      = BASE_W'({row_ptr_q, {OFS_W{1'b0}}});
  assign rem       = BASE_W'(lim) - base;
  assign next_base = base + BASE_W'(WORD_BITS);

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      lo_ok[i] = !first_q || (OFS_W'(i) >= start_q[OFS_W-1:0]);
      hi_ok[i] = BASE_W'(i) < rem;
    end
  end

  assign free_bits = ~used_word & lo_ok & hi_ok;
  assign lowest    = free_bits & (~free_bits + WORD_BITS'(1));

  always_comb begin
    enc = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest[i]) enc = enc | OFS_W'(i);
    end
  end

  assign found_slot = base + BASE_W'(enc);

  assign bit_sel  = slot_q[OFS_W-1:0];
  assign u_bit    = used_word[bit_sel];
  assign m_bit    = mapped_word[bit_sel];
  assign bit_mask = WORD_BITS'(1) << bit_sel;
  assign id_wide  = {16'd0, id_rd_q};

  always_comb begin
    used_wd   = used_word;
    mapped_wd = mapped_word;
    row_we    = 1'b0;
    id_we     = 1'b0;
    id_waddr  = slot_idx;
    st_n      = ST_OK;
    slot_n    = '0;
    id_n      = '0;
    if (is_alloc) begin
      if (|free_bits) begin
        row_we  = 1'b1;
        used_wd = used_word | lowest;
        slot_n  = found_slot[7:0];
        if (action_q == ACT_ALLOC_MAP) begin
          mapped_wd = mapped_word | lowest;
          id_we     = 1'b1;
          id_waddr  = IDX_W'(found_slot);
        end
      end else begin
        st_n = ST_FULL;
      end
    end else begin
      row_we = 1'b1;
      unique case (action_q)
        ACT_CLAIM: begin
          if (m_bit) begin
            mapped_wd = mapped_word & ~bit_mask;
          end else if (u_bit) begin
            st_n = ST_BUSY;
          end else begin
            used_wd = used_word | bit_mask;
          end
        end
        ACT_FREE: begin
          used_wd   = used_word & ~bit_mask;
          mapped_wd = mapped_word & ~bit_mask;
        end
        ACT_MAP: begin
          mapped_wd = mapped_word | bit_mask;
          id_we     = 1'b1;
        end
        ACT_UNMAP: begin
          if (!m_bit) begin
            st_n = ST_INVALID;
          end else begin
            id_n = id_wide[15:0];
            // Reserved slots keep their mapping.
            if (slot_q >= 16'(RESERVED_SLOTS)) mapped_wd = mapped_word & ~bit_mask;
          end
        end
        ACT_LOOKUP: begin
          if (!m_bit) st_n = ST_INVALID;
          else        id_n = id_wide[15:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && row_we) begin
      used_mem[row_ptr_q]   <= used_wd;
      mapped_mem[row_ptr_q] <= mapped_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && id_we) begin
      id_mem[id_waddr] <= sid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (cmd_i.eval && row_we) begin
      row_vld_q[row_ptr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fail) begin
      res_status_q <= is_alloc ? ST_FULL : ST_INVALID;
      res_slot_q   <= '0;
      res_id_q     <= '0;
    end else if (cmd_i.eval) begin
      res_status_q <= st_n;
      res_slot_q   <= slot_n;
      res_id_q     <= id_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o        <= res_status_q;
      slot_out_o      <= res_slot_q;
      system_id_out_o <= res_id_q;
    end
  end

  assign sts_o.oor      = is_alloc ? (start_q >= 16'(lim)) : (slot_q >= 16'(lim));
  assign sts_o.is_alloc = is_alloc;
  assign sts_o.found    = |free_bits;
  assign sts_o.last_row = next_base >= BASE_W'(lim);

endmodule

@@ rtl/descriptor_allocate_map_table.sv @@
// Top level of the descriptor allocate/map table.
// Instantiates damt_ctrl and damt_dp; types and codes come from damt_pkg.
//
// This block keeps a table of descriptor slots, each with a used bit, a mapped
// bit and a stored system identifier, and answers one word of result for every
// input word. Allocation returns the lowest free slot at or above the larger
// of min_slot and the reserved count; the other actions claim, free, map,
// unmap, look up or range-check one slot. Slots at or above the effective
// limit, which is the slot_limit register capped at the table size, are
// rejected. The bitmaps are held in 32-slot rows with a valid bit per row, so
// the table is clean right after reset and needs no clearing pass. Each item
// passes a range check, a search that reads R of the 32-slot rows, and a
// result post before the next word is taken. R is 0 when the addressed slot
// or the allocation start is at or above the limit, 1 for every other
// non-allocating action and for an allocation that finds its slot in the
// first row, and at most the number of rows below the limit (8 for the
// default table); the single read port of the bitmap memories reads one row
// per cycle. The finished result sits in an output register, so a new word
// is taken while the previous result waits on out_stall_i; a second finished
// result waits inside the block until the output register frees up. The
// slot_limit register is written through the configuration channel, which is
// always ready; write it only while the block is idle.
module descriptor_allocate_map_table
  import damt_pkg::*;
#(
  parameter int SLOTS          = 256,
  parameter int RESERVED_SLOTS = 3,
  parameter int ID_WIDTH       = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_slot_limit_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [15:0] slot_i,
  input  logic [15:0] min_slot_i,
  input  logic [15:0] system_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  slot_out_o,
  output logic [15:0] system_id_out_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  // The limit register can take a write in any cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  damt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  damt_dp #(
    .SLOTS          (SLOTS),
    .RESERVED_SLOTS (RESERVED_SLOTS),
    .ID_WIDTH       (ID_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_slot_limit_i (cfg_slot_limit_i),
    .action_i         (action_i),
    .slot_i           (slot_i),
    .min_slot_i       (min_slot_i),
    .system_id_i      (system_id_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .status_o         (status_o),
    .slot_out_o       (slot_out_o),
    .system_id_out_o  (system_id_out_o)
  );

endmodule

@@ rtl/damt_checker.sv @@
// Port-level checker of the descriptor allocate/map table, bound to the top.
// Depends on damt_pkg for the status codes.
module damt_checker
  import damt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [7:0]  slot_out_o,
  input logic [15:0] system_id_out_o
);

  // A stalled result stays and holds its word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(slot_out_o) && $stable(system_id_out_o))
    else $error("stalled result changed");

  // The block works on one word at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken in back-to-back cycles");

  // An error result carries no slot and no identifier.
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> slot_out_o == 8'd0 && system_id_out_o == 16'd0)
    else $error("error result with nonzero fields");

  // A returned identifier never comes with an allocated slot.
  a_id_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && system_id_out_o != 16'd0 |-> slot_out_o == 8'd0)
    else $error("identifier and slot both returned");

endmodule

bind descriptor_allocate_map_table damt_checker u_damt_checker (.*);
